>>> sv/assert_macros.svh
// Assertion helpers for the fixed-point ALU
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge out of reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/fpa_pkg.sv
package fpa_pkg;

	localparam int unsigned FRAC_BITS_DEF = 8;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [3:0] {
		OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
		OP_GT = 4'd4, OP_LT = 4'd5, OP_GE = 4'd6, OP_LE = 4'd7,
		OP_EQ = 4'd8, OP_NE = 4'd9, OP_MIN = 4'd10, OP_MAX = 4'd11,
		OP_INC = 4'd12, OP_DEC = 4'd13, OP_FROM_INT = 4'd14, OP_TO_INT = 4'd15
	} op_t;

endpackage

>>> sv/fpa_div_pipe.sv
// Pipelined restoring divider: one stage per quotient bit, stalls as a whole.
// Divides an unsigned NUM_W-bit numerator by a 32-bit divisor, quotient low 32 bits.
module fpa_div_pipe #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        adv,
	input  logic [32+FRAC_BITS-1:0] num,
	input  logic [31:0] den,
	output logic [31:0] quot
);
	localparam int unsigned NUM_W = 32 + FRAC_BITS;

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		// per-stage partial remainder, remaining numerator bits, divisor, quotient
		logic [32:0]      rem_q;
		logic [NUM_W-1:0] num_q;
		logic [31:0]      den_q;
		logic [31:0]      quo_q;
		logic [32:0]      rem_in;
		logic [NUM_W-1:0] num_in;
		logic [31:0]      den_in;
		logic [31:0]      quo_in;
		logic [33:0]      trial;
		logic [33:0]      shifted;

		// take the first stage from the ports, the rest from the stage before
		if (i == 0) begin : g_head
			assign rem_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_body
			assign rem_in = g_stage[i-1].rem_q;
			assign num_in = g_stage[i-1].num_q;
			assign den_in = g_stage[i-1].den_q;
			assign quo_in = g_stage[i-1].quo_q;
		end

		always_comb begin
			shifted = {rem_in, num_in[NUM_W-1]};
			trial = shifted - {2'b00, den_in};
		end
		// advance one quotient bit per stage
		always_ff @(posedge clk) begin
			if (adv) begin
				if (!trial[33]) begin
					rem_q <= trial[32:0];
				end else begin
					rem_q <= shifted[32:0];
				end
				num_q <= {num_in[NUM_W-2:0], 1'b0};
				den_q <= den_in;
				quo_q <= {quo_in[30:0], ~trial[33]};
			end
		end
	end

	assign quot = g_stage[NUM_W-1].quo_q;
endmodule

>>> sv/fixed_point_alu_unit.sv
// Fixed-point ALU, fully pipelined, one operation accepted per cycle unless out is held.
// Every opcode takes the same path: stage 1 register, the side delay line (its depth
// set by the one-bit-per-stage divider), then the output register.
// Throughput: one operation per cycle; the whole pipe stalls when out is held.
// Reset: arst_n clears every stage valid bit asynchronously; data is not reset.
module fixed_point_alu_unit #(
	parameter int unsigned FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  req_type,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [31:0] result_value,
	output logic        compare_true,
	output logic        divide_by_zero
);
`include "assert_macros.svh"

	localparam int unsigned NUM_W = 32 + FRAC_BITS;

	// stall whole pipe only when the output holds an untaken result
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// stage 1: magnitudes, signs, simple results
	logic [31:0] mag_a, mag_b;
	logic        neg_a, neg_b;
	logic        lt_ab, lt_ba;
	logic [31:0] simple_res;
	logic        simple_cmp;
	fpa_pkg::op_t op_in;

	always_comb begin
		op_in = fpa_pkg::op_t'(req_type);
		neg_a = operand_a[31];
		neg_b = operand_b[31];
		mag_a = neg_a ? (32'd0 - operand_a) : operand_a;
		mag_b = neg_b ? (32'd0 - operand_b) : operand_b;
		lt_ab = operand_a < operand_b;
		lt_ba = operand_b < operand_a;
		simple_res = '0;
		simple_cmp = 1'b0;
		unique case (op_in)
			fpa_pkg::OP_ADD:      simple_res = operand_a + operand_b;
			fpa_pkg::OP_SUB:      simple_res = operand_a - operand_b;
			fpa_pkg::OP_MUL:      simple_res = '0;
			fpa_pkg::OP_DIV:      simple_res = '0;
			fpa_pkg::OP_GT:       simple_cmp = lt_ba;
			fpa_pkg::OP_LT:       simple_cmp = lt_ab;
			fpa_pkg::OP_GE:       simple_cmp = !lt_ab;
			fpa_pkg::OP_LE:       simple_cmp = !lt_ba;
			fpa_pkg::OP_EQ:       simple_cmp = operand_a == operand_b;
			fpa_pkg::OP_NE:       simple_cmp = operand_a != operand_b;
			fpa_pkg::OP_MIN:      simple_res = lt_ab ? operand_a : operand_b;
			fpa_pkg::OP_MAX:      simple_res = lt_ba ? operand_a : operand_b;
			fpa_pkg::OP_INC:      simple_res = operand_a + 32'd1;
			fpa_pkg::OP_DEC:      simple_res = operand_a - 32'd1;
			fpa_pkg::OP_FROM_INT: simple_res = operand_a << FRAC_BITS;
			fpa_pkg::OP_TO_INT:   simple_res = operand_a >>> FRAC_BITS;
			default:              simple_res = '0;
		endcase
	end

	logic        v_s1;
	logic [3:0]  op_s1;
	logic [31:0] ma_s1, mb_s1, res_s1;
	logic        neg_s1, cmp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1 <= req_type;
			ma_s1 <= mag_a;
			mb_s1 <= mag_b;
			res_s1 <= simple_res;
			cmp_s1 <= simple_cmp;
			neg_s1 <= neg_a ^ neg_b;
		end
	end

	// stage 2: unsigned product register
	logic [63:0] prod_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s2 <= ma_s1 * mb_s1;
		end
	end

	// divider runs alongside; starts from stage 1 magnitudes
	logic [31:0] quot;
	fpa_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .adv(adv),
		.num({ma_s1, {FRAC_BITS{1'b0}}}), .den(mb_s1), .quot(quot)
	);

	// stage 3: scaled product magnitude
	logic [31:0] pmag_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			pmag_s3 <= prod_s2[FRAC_BITS +: 32];
		end
	end

	// side delay line for control and simple results; product taps its level
	localparam int unsigned SD = NUM_W;
	logic        v_d   [SD];
	logic [3:0]  op_d  [SD];
	logic [31:0] res_d [SD];
	logic        cmp_d [SD], neg_d [SD], dz_d [SD];
	logic [31:0] pm_d  [SD];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SD; i++) begin
				v_d[i] <= 1'b0;
			end
		end else if (adv) begin
			v_d[0] <= v_s1;
			for (int i = 1; i < SD; i++) begin
				v_d[i] <= v_d[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_d[0] <= op_s1;
			res_d[0] <= res_s1;
			cmp_d[0] <= cmp_s1;
			neg_d[0] <= neg_s1;
			dz_d[0] <= (mb_s1 == 32'd0);
			pm_d[0] <= '0;
			for (int i = 1; i < SD; i++) begin
				op_d[i] <= op_d[i-1];
				res_d[i] <= res_d[i-1];
				cmp_d[i] <= cmp_d[i-1];
				neg_d[i] <= neg_d[i-1];
				dz_d[i] <= dz_d[i-1];
				pm_d[i] <= (i == 2) ? pmag_s3 : pm_d[i-1];
			end
		end
	end

	// final stage: select, apply sign (divider output aligns with tap NUM_W-1)
	localparam int unsigned T = NUM_W - 1;
	logic [31:0] fin_res;
	logic        fin_dz;
	always_comb begin
		fin_res = res_d[T];
		fin_dz = 1'b0;
		if (op_d[T] == fpa_pkg::OP_MUL) begin
			fin_res = neg_d[T] ? (32'd0 - pm_d[T]) : pm_d[T];
		end else if (op_d[T] == fpa_pkg::OP_DIV) begin
			fin_dz = dz_d[T];
			fin_res = dz_d[T] ? 32'd0 : (neg_d[T] ? (32'd0 - quot) : quot);
		end
	end

	logic        v_out_q;
	logic [31:0] res_q;
	logic        cmp_q, dz_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (adv) begin
			v_out_q <= v_d[T];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= fin_res;
			cmp_q <= cmp_d[T];
			dz_q <= fin_dz;
		end
	end

	assign out_valid = v_out_q;
	assign result_value = res_q;
	assign compare_true = cmp_q;
	assign divide_by_zero = dz_q;

	`ASSERT_IMPL(a_flags_excl, clk, arst_n, out_valid, !(compare_true && divide_by_zero), "both flags set")
	`ASSERT_IMPL(a_dz_zero, clk, arst_n, out_valid && divide_by_zero, result_value == 32'd0, "dz result not zero")
	`ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(result_value), "output dropped under stall")
	`ASSERT_IMPL(a_cmp_zero, clk, arst_n, out_valid && compare_true, result_value == 32'd0, "compare result not zero")
endmodule
